[hdl/sn7seg_pkg.sv]
// ----------------------------------------------------------------------------
// sn7seg_pkg
// Shared types and constants for the signed number to seven-segment converter.
// ----------------------------------------------------------------------------
package sn7seg_pkg;

  localparam int unsigned NUM_POS = 4;

  // reciprocal multipliers, exact for the value ranges they see
  localparam logic [31:0] RECIP_1000 = 32'd33555;  // x < 59074
  localparam int unsigned SHIFT_1000 = 25;
  localparam logic [15:0] RECIP_100  = 16'd41;     // x < 1000
  localparam int unsigned SHIFT_100  = 12;
  localparam logic [15:0] RECIP_10   = 16'd205;    // x < 1029
  localparam int unsigned SHIFT_10   = 11;

  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;

  // item as it moves down the pipeline; later stages fill the later fields
  typedef struct packed {
    logic        neg;
    logic        oor;
    logic [15:0] mag;
    logic [5:0]  q1000;
    logic [9:0]  rem1000;
    logic [3:0]  q_thou;
    digit_t      dig0;
    digit_t      dig1;
    logic [6:0]  rem100;
    digit_t      q_tens;
  } pipe_t;

  function automatic seg_t font(input digit_t d);
    seg_t s;
    case (d)
      4'h0: s = 8'h3F;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5B;
      4'h3: s = 8'h4F;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6D;
      4'h6: s = 8'h7D;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h77;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h39;
      4'hD: s = 8'h5E;
      4'hE: s = 8'h79;
      4'hF: s = 8'h71;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

[hdl/sn7seg_mag.sv]
// ----------------------------------------------------------------------------
// sn7seg_mag
// First stage: sign, magnitude and range flag of the input value.
// ----------------------------------------------------------------------------
module sn7seg_mag (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output sn7seg_pkg::pipe_t   out_data
);
  import sn7seg_pkg::*;

  pipe_t data_next;
  logic [15:0] mag_w;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next     = '0;
    data_next.neg = value[15];
    // most negative value keeps magnitude 0x8000 as unsigned
    mag_w         = value[15] ? (16'd0 - value) : value;
    data_next.mag = mag_w;
    data_next.oor = value[15] ? (mag_w > 16'd999) : (mag_w > 16'd9999);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[hdl/sn7seg_digits.sv]
// ----------------------------------------------------------------------------
// sn7seg_digits
// Five stages that split the magnitude into the thousands, hundreds and tens
// digits by reciprocal multiplication, one or two small multiplies per stage.
// ----------------------------------------------------------------------------
module sn7seg_digits (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sn7seg_pkg::pipe_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sn7seg_pkg::pipe_t  out_data
);
  import sn7seg_pkg::*;

  localparam int unsigned NSTG = 5;

  logic  [NSTG-1:0] valid;
  logic  [NSTG-1:0] adv;
  logic  [NSTG-1:0] src_valid;
  pipe_t            data [NSTG];
  pipe_t            src  [NSTG];
  pipe_t            data_next [NSTG];

  logic [31:0] prod_q1000;
  logic [15:0] prod_rem;
  logic [15:0] prod_thou;
  logic [15:0] prod_hund;
  logic [15:0] prod_rem100;
  logic [15:0] prod_tens;

  assign src[0]       = in_data;
  assign src_valid[0] = in_valid;

  for (genvar k = 1; k < NSTG; k++) begin : g_link
    assign src[k]       = data[k-1];
    assign src_valid[k] = valid[k-1];
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_adv
    if (k == NSTG - 1) begin : g_last
      assign adv[k] = !valid[k] || out_ready;
    end else begin : g_mid
      assign adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      data_next[k] = src[k];
    end
    // thousands quotient
    prod_q1000         = {16'd0, src[0].mag} * RECIP_1000;
    data_next[0].q1000 = 6'(prod_q1000 >> SHIFT_1000);
    // remainder below 1000 and quotient of thousands by ten
    prod_rem             = 16'(src[1].q1000) * 16'd1000;
    data_next[1].rem1000 = 10'(src[1].mag - prod_rem);
    prod_thou            = 16'(src[1].q1000) * RECIP_10;
    data_next[1].q_thou  = 4'(prod_thou >> SHIFT_10);
    // thousands digit (mod 10) and hundreds digit
    data_next[2].dig0 = 4'(src[2].q1000 - 6'(src[2].q_thou * 4'd10));
    prod_hund         = 16'(src[2].rem1000) * RECIP_100;
    data_next[2].dig1 = 4'(prod_hund >> SHIFT_100);
    // remainder below 100
    prod_rem100         = 16'(src[3].dig1) * 16'd100;
    data_next[3].rem100 = 7'(16'(src[3].rem1000) - prod_rem100);
    // tens digit
    prod_tens           = 16'(src[4].rem100) * RECIP_10;
    data_next[4].q_tens = 4'(prod_tens >> SHIFT_10);
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv[k]) begin
        valid[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && src_valid[k]) begin
        data[k] <= data_next[k];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid[NSTG-1];
  assign out_data  = data[NSTG-1];

endmodule

[hdl/sn7seg_format.sv]
// ----------------------------------------------------------------------------
// sn7seg_format
// Output stage: units digit, leading-zero blanking, minus sign and font.
// ----------------------------------------------------------------------------
module sn7seg_format (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sn7seg_pkg::pipe_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         seg_pos0,
  output logic [7:0]         seg_pos1,
  output logic [7:0]         seg_pos2,
  output logic [7:0]         seg_pos3,
  output logic               out_of_range
);
  import sn7seg_pkg::*;

  digit_t dig  [NUM_POS];
  seg_t   seg  [NUM_POS];
  logic [1:0] msd;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dig[0] = in_data.dig0;
    dig[1] = in_data.dig1;
    dig[2] = in_data.q_tens;
    dig[3] = 4'(in_data.rem100 - 7'(in_data.q_tens * 4'd10));
    // first nonzero digit, units always shown
    if (dig[0] != 4'd0) begin
      msd = 2'd0;
    end else if (dig[1] != 4'd0) begin
      msd = 2'd1;
    end else if (dig[2] != 4'd0) begin
      msd = 2'd2;
    end else begin
      msd = 2'd3;
    end
    for (int i = 0; i < NUM_POS; i++) begin
      seg[i] = (2'(i) >= msd) ? font(dig[i]) : SEG_BLANK;
    end
    if (in_data.neg && msd != 2'd0) begin
      seg[msd - 2'd1] = SEG_MINUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seg_pos0     <= seg[0];
      seg_pos1     <= seg[1];
      seg_pos2     <= seg[2];
      seg_pos3     <= seg[3];
      out_of_range <= in_data.oor;
    end
  end

endmodule

[hdl/signed_number_to_seven_segment_top.sv]
// ----------------------------------------------------------------------------
// signed_number_to_seven_segment_top
// Signed 16-bit value to four seven-segment bytes with sign and range flag.
// ----------------------------------------------------------------------------
// One value per cycle goes in while the pipeline is not stalled. Each result
// passes through one stage for sign and magnitude, five stages of reciprocal
// multiplies that peel off the decimal digits, and one output stage that
// blanks leading zeros, places the minus and looks up the font. Every stage
// has its own valid bit and moves whenever the stage after it has room, so a
// stalled output only holds the items behind it and bubbles are squeezed out.
module signed_number_to_seven_segment_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         seg_pos0,
  output logic [7:0]         seg_pos1,
  output logic [7:0]         seg_pos2,
  output logic [7:0]         seg_pos3,
  output logic               out_of_range
);
  import sn7seg_pkg::*;

  logic  mag_valid;
  logic  mag_ready;
  pipe_t mag_data;
  logic  dig_valid;
  logic  dig_ready;
  pipe_t dig_data;

  sn7seg_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_data  (mag_data)
  );

  sn7seg_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mag_valid),
    .in_ready  (mag_ready),
    .in_data   (mag_data),
    .out_valid (dig_valid),
    .out_ready (dig_ready),
    .out_data  (dig_data)
  );

  sn7seg_format u_format (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dig_valid),
    .in_ready     (dig_ready),
    .in_data      (dig_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_pos0     (seg_pos0),
    .seg_pos1     (seg_pos1),
    .seg_pos2     (seg_pos2),
    .seg_pos3     (seg_pos3),
    .out_of_range (out_of_range)
  );

endmodule

[tb/tb_signed_number_to_seven_segment_top.sv]
// ----------------------------------------------------------------------------
// tb_signed_number_to_seven_segment_top
// Self-checking bench for the signed number to seven-segment converter.
// ----------------------------------------------------------------------------
// Values go in over a valid/ready channel with random gaps. Each transfer is
// predicted on the spot: digits, leading-zero blanking, minus placement and
// the range flag. The expected displays wait in a queue, and every output
// transfer is compared field by field with the oldest one. Directed corner
// values come first, then random values with and without idling, and a phase
// that lets the pipeline drain completely in the middle of the stream.
// ----------------------------------------------------------------------------
module tb_signed_number_to_seven_segment_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sn7seg_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] pos0;
    logic [7:0] pos1;
    logic [7:0] pos2;
    logic [7:0] pos3;
    logic       oor;
  } display_t;

  // decimal glyphs, point off
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         seg_pos0;
  logic [7:0]         seg_pos1;
  logic [7:0]         seg_pos2;
  logic [7:0]         seg_pos3;
  logic               out_of_range;

  display_t pending_displays[$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  bit       idle_in = 1'b0;
  bit       idle_out = 1'b0;

  int corner_values [25] = '{
    0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 20000, 32767,
    -1, -9, -10, -99, -100, -105, -999, -1000, -1001, -9999, -10000,
    -32767, -32768
  };

  signed_number_to_seven_segment_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_pos0     (seg_pos0),
    .seg_pos1     (seg_pos1),
    .seg_pos2     (seg_pos2),
    .seg_pos3     (seg_pos3),
    .out_of_range (out_of_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic display_t predict_display(input logic [15:0] raw);
    logic        neg;
    int unsigned mag;
    int unsigned dig [4];
    logic [7:0]  seg [4];
    int          lead;
    display_t    d;
    neg = raw[15];
    // -32768 keeps magnitude 32768, no sign bit left over
    mag = neg ? (32'h10000 - {16'h0, raw}) : {16'h0, raw};
    dig[0] = (mag / 1000) % 10;
    dig[1] = (mag / 100) % 10;
    dig[2] = (mag / 10) % 10;
    dig[3] = mag % 10;
    lead = 3;
    for (int i = 2; i >= 0; i--) begin
      if (dig[i] != 0) lead = i;
    end
    for (int i = 0; i < 4; i++) begin
      seg[i] = (i >= lead) ? DIGIT_GLYPH[dig[i]] : SEG_BLANK;
    end
    if (neg && lead > 0) seg[lead - 1] = SEG_MINUS;
    d.pos0 = seg[0];
    d.pos1 = seg[1];
    d.pos2 = seg[2];
    d.pos3 = seg[3];
    d.oor  = neg ? (mag > 999) : (mag > 9999);
    return d;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_val,
               act_val);
    end
  endfunction

  // transfer monitor, display checker and watchdog
  always @(posedge clk) begin
    display_t exp_disp;
    if (!rst) begin
      if (in_valid && in_ready) pending_displays.push_back(predict_display(value));
      if (out_valid && out_ready) begin
        if (pending_displays.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %02h %02h %02h %02h %b",
                   $time, seg_pos0, seg_pos1, seg_pos2, seg_pos3, out_of_range);
        end else begin
          exp_disp = pending_displays.pop_front();
          check_field("seg_pos0", exp_disp.pos0, seg_pos0);
          check_field("seg_pos1", exp_disp.pos1, seg_pos1);
          check_field("seg_pos2", exp_disp.pos2, seg_pos2);
          check_field("seg_pos3", exp_disp.pos3, seg_pos3);
          check_field("out_of_range", {7'h0, exp_disp.oor}, {7'h0, out_of_range});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // output back-pressure, a fresh stall drawn after every output transfer
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_ready && out_valid) begin
      stall_left = idle_out ? $urandom_range(0, 9) : 0;
      out_ready <= (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_value(input logic [15:0] raw);
    int gap;
    gap = idle_in ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int v;
    int p;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: v = int'($urandom_range(0, 10998)) - 999;
      2: begin
        // around a power of ten, either sign
        p = 1;
        repeat ($urandom_range(0, 4)) p *= 10;
        v = p + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = int'($urandom_range(0, 198)) - 99;
    endcase
    return v[15:0];
  endfunction

  task automatic test_corner_values();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    foreach (corner_values[i]) send_value(corner_values[i][15:0]);
  endtask

  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        idle_in  = 1'($urandom_range(0, 1));
        idle_out = 1'($urandom_range(0, 1));
      end
      send_value(pick_value());
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    for (int i = 0; i < count; i++) send_value(pick_value());
  endtask

  task automatic test_drain_midstream(input int count);
    idle_in  = 1'b1;
    idle_out = 1'b1;
    for (int i = 0; i < count; i++) send_value(pick_value());
    wait_for_drain();
    idle_in = 1'b0;
    for (int i = 0; i < count; i++) send_value(pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_random_values(1200);
    test_back_to_back(600);
    test_drain_midstream(60);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
